/* sv/ircc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ircc_pkg
// Shared types and constants of the interval resource conflict checker.
// ----------------------------------------------------------------------------
package ircc_pkg;

  localparam int TABLE_DEPTH    = 32;
  localparam int BATCH_DEPTH    = 8;
  localparam int TARGET_COUNT   = 32;
  localparam int RESOURCE_COUNT = 32;
  localparam int TICK_BITS      = 48;

  // Request codes.
  localparam logic [1:0] FUNC_STAGE   = 2'd0;
  localparam logic [1:0] FUNC_DISCARD = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  // Action kinds.
  localparam logic [2:0] KIND_PULSE = 3'd0;
  localparam logic [2:0] KIND_GATE  = 3'd1;
  localparam logic [2:0] KIND_ACQ   = 3'd2;
  localparam logic [2:0] KIND_ARM   = 3'd3;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PROTOCOL = 3'd1;
  localparam logic [2:0] ST_CONFLICT = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BATCH    = 3'd4;

  // Action record as stored in the table and batch memories.
  typedef struct packed {
    logic [31:0]               id;
    logic [TICK_BITS-1:0]      start;
    logic [TICK_BITS-1:0]      stop;
    logic [7:0]                port;
    logic [2:0]                kind;
    logic [TARGET_COUNT-1:0]   targets;
    logic [RESOURCE_COUNT-1:0] res;
    logic [RESOURCE_COUNT-1:0] excl;
  } act_t;

  localparam int ACT_BITS = $bits(act_t);

endpackage
`default_nettype wire

/* sv/ircc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ircc_in_if / ircc_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface ircc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] action_id;
  logic [47:0] start_tick;
  logic [47:0] end_tick;
  logic [7:0]  out_port;
  logic [2:0]  kind;
  logic [31:0] target_mask;
  logic [31:0] resource_mask;
  logic [31:0] exclusive_mask;
  logic        last;
  modport source (output valid, func, action_id, start_tick, end_tick, out_port, kind,
                  target_mask, resource_mask, exclusive_mask, last, input ready);
  modport sink (input valid, func, action_id, start_tick, end_tick, out_port, kind,
                target_mask, resource_mask, exclusive_mask, last, output ready);
endinterface

interface ircc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       committed;
  logic [5:0] occupancy;
  modport source (output valid, status, committed, occupancy, input ready);
  modport sink (input valid, status, committed, occupancy, output ready);
endinterface
`default_nettype wire

/* sv/ircc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ircc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ircc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/interval_resource_conflict_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_resource_conflict_checker
// Reservation table for timed actions with batched staging and commit.
// ----------------------------------------------------------------------------
// One request beat is handled at a time. For a staged action, a sequencer walks
// the batch memory for repeated ids, then the table memory oldest first, then
// the batch memory again for conflicts, one entry a cycle through the single
// read port of each memory. The first failure ends the walks early, and an
// action staged after a failure or beyond the batch limit goes straight to its
// result. A last beat of a clean batch that fits the table then copies the
// batch into the table. A discard walks the table once, one row a cycle, and
// compacts it in place; a clear or an unused code goes straight to its result.
// Each request gives one result beat, held in an output register; the next
// request is accepted no earlier than the edge at which that beat is accepted.
// ----------------------------------------------------------------------------
module interval_resource_conflict_checker #(
  parameter int TABLE_DEPTH = ircc_pkg::TABLE_DEPTH,
  parameter int BATCH_DEPTH = ircc_pkg::BATCH_DEPTH
) (
  input wire logic clk,
  input wire logic rst,
  ircc_in_if.sink  req,
  ircc_out_if.source rsp
);

  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int BW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int TC = $clog2(TABLE_DEPTH + 1);
  localparam int BC = $clog2(BATCH_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DUP   = 3'd1;
  localparam logic [2:0] S_TAB   = 3'd2;
  localparam logic [2:0] S_BAT   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_DISC  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]    state;
  logic [TC-1:0] table_count;
  logic [BC-1:0] staged_count;
  logic [2:0]    batch_status;
  ircc_pkg::act_t cur;
  logic          cur_last;
  logic [TC:0]   idx;       // index of the issued read
  logic          rd_pend;   // rdata holds valid read data
  logic [TC:0]   kept;
  logic [2:0]    eval;
  logic          out_valid;
  logic [2:0]    out_status;
  logic          out_commit;

  // Memory ports.
  logic           t_we, b_we;
  logic [TW-1:0]  t_waddr, t_raddr;
  logic [BW-1:0]  b_waddr, b_raddr;
  ircc_pkg::act_t t_wdata, t_rdata, b_wdata, b_rdata;

  ircc_ram #(.WIDTH(ircc_pkg::ACT_BITS), .DEPTH(TABLE_DEPTH)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  ircc_ram #(.WIDTH(ircc_pkg::ACT_BITS), .DEPTH(1 << BW)) u_batch (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // Conflict rule between the current action and a stored one.
  function automatic logic clash(ircc_pkg::act_t a, ircc_pkg::act_t b);
    logic ov, cm;
    ov = (a.start < b.stop) && (b.start < a.stop);
    cm = (a.targets & b.targets) != '0;
    clash = 1'b0;
    if (ov) begin
      if (a.port == b.port) clash = 1'b1;
      if (((a.res & b.res) & (a.excl | b.excl)) != '0) clash = 1'b1;
      if (cm && a.kind != ircc_pkg::KIND_ARM && b.kind != ircc_pkg::KIND_ARM &&
          !(a.kind == ircc_pkg::KIND_PULSE && b.kind == ircc_pkg::KIND_PULSE))
        clash = 1'b1;
    end
    if (cm) begin
      if (a.kind == ircc_pkg::KIND_ACQ && b.kind == ircc_pkg::KIND_GATE &&
          a.stop == b.start) clash = 1'b1;
      if (b.kind == ircc_pkg::KIND_ACQ && a.kind == ircc_pkg::KIND_GATE &&
          b.stop == a.start) clash = 1'b1;
    end
  endfunction

  assign req.ready     = (state == S_IDLE) && !(out_valid && !rsp.ready);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.committed = out_commit;
  assign rsp.occupancy = 6'(table_count);

  logic [TC:0] tcount_w;
  logic [TC:0] scount_w;
  assign tcount_w = (TC+1)'(table_count);
  assign scount_w = (TC+1)'(staged_count);

  // Memory port control.
  always_comb begin
    t_we    = 1'b0;
    t_waddr = kept[TW-1:0];
    t_wdata = t_rdata;
    t_raddr = idx[TW-1:0];
    b_we    = 1'b0;
    b_waddr = staged_count[BW-1:0];
    b_wdata = cur;
    b_raddr = idx[BW-1:0];
    unique case (state)
      S_FIN: b_we = (staged_count < BC'(BATCH_DEPTH));
      S_COPY: begin
        t_we    = rd_pend;
        t_waddr = TW'(tcount_w + kept);
        t_wdata = b_rdata;
      end
      S_DISC: t_we = rd_pend && !(t_rdata.stop < cur.start);
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      table_count  <= '0;
      staged_count <= '0;
      batch_status <= ircc_pkg::ST_OK;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      // The result register is only loaded once the previous beat has gone.
      if (state == S_OUT) out_valid <= 1'b1;
      else if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur.id      <= req.action_id;
            cur.start   <= req.start_tick;
            cur.stop    <= req.end_tick;
            cur.port    <= req.out_port;
            cur.kind    <= req.kind;
            cur.targets <= req.target_mask;
            cur.res     <= req.resource_mask;
            cur.excl    <= req.exclusive_mask & req.resource_mask;
            cur_last    <= req.last;
            idx         <= '0;
            rd_pend     <= 1'b0;
            kept        <= '0;
            eval        <= ircc_pkg::ST_OK;
            unique case (req.func)
              ircc_pkg::FUNC_STAGE: begin
                if (staged_count >= BC'(BATCH_DEPTH) || batch_status != ircc_pkg::ST_OK)
                  state <= S_FIN;
                else
                  state <= S_DUP;
              end
              ircc_pkg::FUNC_DISCARD: begin
                staged_count <= '0;
                batch_status <= ircc_pkg::ST_OK;
                state        <= S_DISC;
              end
              ircc_pkg::FUNC_CLEAR: begin
                staged_count <= '0;
                batch_status <= ircc_pkg::ST_OK;
                table_count  <= '0;
                out_status   <= ircc_pkg::ST_OK;
                out_commit   <= 1'b0;
                state        <= S_OUT;
              end
              default: begin
                out_status <= ircc_pkg::ST_OK;
                out_commit <= 1'b0;
                state      <= S_OUT;
              end
            endcase
          end
        end
        // Repeated id within the batch.
        S_DUP: begin
          if (rd_pend && b_rdata.id == cur.id) begin
            eval <= ircc_pkg::ST_PROTOCOL;
            state <= S_FIN;
          end else if (idx < scount_w) begin
            idx <= idx + 1'b1; rd_pend <= 1'b1;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else begin
            idx <= '0; state <= S_TAB;
          end
        end
        // Table entries, oldest first.
        S_TAB: begin
          if (rd_pend && t_rdata.id == cur.id) begin
            eval <= ircc_pkg::ST_PROTOCOL; state <= S_FIN;
          end else if (rd_pend && clash(cur, t_rdata)) begin
            eval <= ircc_pkg::ST_CONFLICT; state <= S_FIN;
          end else if (idx < tcount_w) begin
            idx <= idx + 1'b1; rd_pend <= 1'b1;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else begin
            idx <= '0; state <= S_BAT;
          end
        end
        // Conflicts with earlier actions of the batch.
        S_BAT: begin
          if (rd_pend && clash(cur, b_rdata)) begin
            eval <= ircc_pkg::ST_CONFLICT; state <= S_FIN;
          end else if (idx < scount_w) begin
            idx <= idx + 1'b1; rd_pend <= 1'b1;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else begin
            state <= S_FIN;
          end
        end
        // Store the action and settle the batch status.
        S_FIN: begin
          logic [2:0]    bs;
          logic [BC-1:0] sc;
          bs = batch_status;
          sc = staged_count;
          if (staged_count >= BC'(BATCH_DEPTH)) begin
            if (bs == ircc_pkg::ST_OK) bs = ircc_pkg::ST_BATCH;
          end else begin
            if (bs == ircc_pkg::ST_OK) bs = eval;
            sc = sc + 1'b1;
          end
          idx     <= '0;
          rd_pend <= 1'b0;
          if (cur_last) begin
            batch_status <= ircc_pkg::ST_OK;
            if (bs == ircc_pkg::ST_OK &&
                (tcount_w + (TC+1)'(sc)) > (TC+1)'(TABLE_DEPTH)) begin
              staged_count <= '0;
              out_status   <= ircc_pkg::ST_FULL;
              out_commit   <= 1'b0;
              state        <= S_OUT;
            end else if (bs == ircc_pkg::ST_OK) begin
              staged_count <= sc;
              out_status   <= bs;
              out_commit   <= 1'b1;
              state        <= S_COPY;
            end else begin
              staged_count <= '0;
              out_status   <= bs;
              out_commit   <= 1'b0;
              state        <= S_OUT;
            end
          end else begin
            staged_count <= sc;
            batch_status <= bs;
            out_status   <= bs;
            out_commit   <= 1'b0;
            state        <= S_OUT;
          end
        end
        // Append the batch to the table in order.
        S_COPY: begin
          if (rd_pend) kept <= kept + 1'b1;
          if (idx < scount_w) begin
            idx <= idx + 1'b1; rd_pend <= 1'b1;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else begin
            table_count  <= TC'(tcount_w + kept);
            staged_count <= '0;
            state        <= S_OUT;
          end
        end
        // Compact the table, dropping rows that end before the given tick.
        S_DISC: begin
          if (rd_pend && !(t_rdata.stop < cur.start)) kept <= kept + 1'b1;
          if (idx < tcount_w) begin
            idx <= idx + 1'b1; rd_pend <= 1'b1;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else begin
            table_count <= TC'(kept);
            out_status  <= ircc_pkg::ST_OK;
            out_commit  <= 1'b0;
            state       <= S_OUT;
          end
        end
        // Present the result beat.
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/interval_resource_conflict_checker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_resource_conflict_checker_tb
// Drives staged batches, discards and clears into the reservation table and
// checks every result beat against a behavioural copy of the table.
// ----------------------------------------------------------------------------

// Scoreboard: keeps a model of the table and a queue of expected beats.
class ircc_scoreboard;
  typedef struct packed {
    logic [2:0] status;
    logic       committed;
    logic [5:0] occupancy;
  } verdict_t;

  ircc_pkg::act_t rows[$];
  ircc_pkg::act_t batch[$];
  logic [2:0]     batch_st;
  verdict_t       pending[$];
  int             errors;
  int             commits;
  int             conflicts;

  function new();
    batch_st = ircc_pkg::ST_OK;
    errors = 0;
    commits = 0;
    conflicts = 0;
  endfunction

  // True when two actions may not both hold the table.
  function bit overlaps_badly(ircc_pkg::act_t a, ircc_pkg::act_t b);
    bit ov;
    bit com;
    ov = (a.start < b.stop) && (b.start < a.stop);
    com = (a.targets & b.targets) != 0;
    if (ov) begin
      if (a.port == b.port) return 1;
      if (((a.res & b.res) & ((a.res & a.excl) | (b.res & b.excl))) != 0) return 1;
      if (com && a.kind != ircc_pkg::KIND_ARM && b.kind != ircc_pkg::KIND_ARM &&
          !(a.kind == ircc_pkg::KIND_PULSE && b.kind == ircc_pkg::KIND_PULSE))
        return 1;
    end
    if (com) begin
      if (a.kind == ircc_pkg::KIND_ACQ && b.kind == ircc_pkg::KIND_GATE &&
          a.stop == b.start) return 1;
      if (b.kind == ircc_pkg::KIND_ACQ && a.kind == ircc_pkg::KIND_GATE &&
          b.stop == a.start) return 1;
    end
    return 0;
  endfunction

  function logic [2:0] judge(ircc_pkg::act_t a);
    foreach (batch[i]) if (batch[i].id == a.id) return ircc_pkg::ST_PROTOCOL;
    foreach (rows[i]) begin
      if (rows[i].id == a.id) return ircc_pkg::ST_PROTOCOL;
      if (overlaps_badly(a, rows[i])) return ircc_pkg::ST_CONFLICT;
    end
    foreach (batch[i]) if (overlaps_badly(a, batch[i])) return ircc_pkg::ST_CONFLICT;
    return ircc_pkg::ST_OK;
  endfunction

  // Note an accepted request beat and queue its expected result.
  function void note_request(logic [1:0] fn, ircc_pkg::act_t a, logic lst);
    verdict_t v;
    ircc_pkg::act_t kept[$];
    v = '0;
    if (fn == ircc_pkg::FUNC_STAGE) begin
      a.excl = a.excl & a.res;
      if (batch.size() >= ircc_pkg::BATCH_DEPTH) begin
        if (batch_st == ircc_pkg::ST_OK) batch_st = ircc_pkg::ST_BATCH;
      end else begin
        if (batch_st == ircc_pkg::ST_OK) batch_st = judge(a);
        batch = {batch, a};
      end
      v.status = batch_st;
      if (lst) begin
        if (v.status == ircc_pkg::ST_OK &&
            rows.size() + batch.size() > ircc_pkg::TABLE_DEPTH)
          v.status = ircc_pkg::ST_FULL;
        if (v.status == ircc_pkg::ST_OK) begin
          rows = {rows, batch};
          v.committed = 1'b1;
          commits++;
        end else begin
          conflicts++;
        end
        batch.delete();
        batch_st = ircc_pkg::ST_OK;
      end
    end else if (fn == ircc_pkg::FUNC_DISCARD || fn == ircc_pkg::FUNC_CLEAR) begin
      batch.delete();
      batch_st = ircc_pkg::ST_OK;
      if (fn == ircc_pkg::FUNC_CLEAR) begin
        rows.delete();
      end else begin
        foreach (rows[i]) if (!(rows[i].stop < a.start)) kept = {kept, rows[i]};
        rows = kept;
      end
    end
    v.occupancy = 6'(rows.size());
    pending = {pending, v};
  endfunction

  // Compare one result beat with the oldest expectation.
  function void check_result(logic [2:0] st, logic cm, logic [5:0] occ);
    verdict_t v;
    if (pending.size() == 0) begin
      $error("unexpected result beat");
      errors++;
      return;
    end
    v = pending.pop_front();
    if (st !== v.status) begin
      $error("status: expected %0d, actual %0d", v.status, st);
      errors++;
    end
    if (cm !== v.committed) begin
      $error("committed: expected %0d, actual %0d", v.committed, cm);
      errors++;
    end
    if (occ !== v.occupancy) begin
      $error("occupancy: expected %0d, actual %0d", v.occupancy, occ);
      errors++;
    end
  endfunction
endclass

module interval_resource_conflict_checker_tb;

  localparam int CYCLE_LIMIT = 2000000;
  // Request code with no function.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   beats_sent = 0;

  ircc_in_if  req_ch ();
  ircc_out_if rsp_ch ();
  ircc_scoreboard board = new();

  interval_resource_conflict_checker u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #1 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("interval_resource_conflict_checker_tb NOT OK");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Result side: random back-pressure, check each accepted beat.
  initial begin
    int hold;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = gap_len();
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      board.check_result(rsp_ch.status, rsp_ch.committed, rsp_ch.occupancy);
    end
  end

  // Send one request beat and note it once accepted.
  task automatic send_beat(logic [1:0] fn, ircc_pkg::act_t a, logic lst);
    int pause;
    pause = gap_len();
    if (pause > 0) begin
      req_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.func           <= fn;
    req_ch.action_id      <= a.id;
    req_ch.start_tick     <= a.start;
    req_ch.end_tick       <= a.stop;
    req_ch.out_port       <= a.port;
    req_ch.kind           <= a.kind;
    req_ch.target_mask    <= a.targets;
    req_ch.resource_mask  <= a.res;
    req_ch.exclusive_mask <= a.excl;
    req_ch.last           <= lst;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(fn, a, lst);
    beats_sent++;
  endtask

  // A random action, unless wide in a small tick window so that overlaps are common.
  function automatic ircc_pkg::act_t rand_action(bit wide);
    ircc_pkg::act_t a;
    logic [47:0] len;
    a.id      = wide ? $urandom : 32'($urandom_range(0, 300));
    a.start   = wide ? 48'({$urandom, $urandom}) : 48'($urandom_range(0, 4000));
    len       = 48'($urandom_range(0, 60));
    a.stop    = ($urandom_range(0, 15) == 0) ? 48'({$urandom, $urandom}) : a.start + len;
    a.port    = wide ? 8'($urandom) : 8'($urandom_range(0, 40));
    a.kind    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) :
                3'($urandom_range(0, 3));
    a.targets = wide ? $urandom : (32'h1 << $urandom_range(0, 31)) &
                ($urandom_range(0, 1) ? 32'hffffffff : 32'h0);
    a.res     = wide ? $urandom : (32'h1 << $urandom_range(0, 31));
    a.excl    = $urandom_range(0, 1) ? $urandom : a.res;
    return a;
  endfunction

  // Hold the sender until every expected result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    ircc_pkg::act_t a;
    ircc_pkg::act_t b;
    int   n;
    req_ch.valid = 1'b0;
    req_ch.func = ircc_pkg::FUNC_STAGE;
    req_ch.action_id = '0;
    req_ch.start_tick = '0;
    req_ch.end_tick = '0;
    req_ch.out_port = '0;
    req_ch.kind = ircc_pkg::KIND_PULSE;
    req_ch.target_mask = '0;
    req_ch.resource_mask = '0;
    req_ch.exclusive_mask = '0;
    req_ch.last = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, each kind of conflict and each command.
    a = '{id: 32'hffffffff, start: 48'h0, stop: 48'hffffffffffff, port: 8'hff,
          kind: ircc_pkg::KIND_PULSE, targets: 32'hffffffff, res: 32'hffffffff,
          excl: 32'h0};
    send_beat(ircc_pkg::FUNC_STAGE, a, 1'b1);
    b = a; b.id = 32'd1; b.port = 8'd0; b.res = '0;
    send_beat(ircc_pkg::FUNC_STAGE, b, 1'b1);       // two pulses on shared targets
    b.id = 32'd2; b.kind = ircc_pkg::KIND_GATE;
    send_beat(ircc_pkg::FUNC_STAGE, b, 1'b1);       // gate against pulse
    b.id = 32'd3; b.kind = ircc_pkg::KIND_ARM;
    send_beat(ircc_pkg::FUNC_STAGE, b, 1'b1);       // arm never clashes on targets
    b.id = 32'd4; b.kind = ircc_pkg::KIND_PULSE; b.port = 8'hff;
    send_beat(ircc_pkg::FUNC_STAGE, b, 1'b1);       // same port
    b.id = 32'hffffffff; b.port = 8'd9;
    send_beat(ircc_pkg::FUNC_STAGE, b, 1'b1);       // repeated id in the table
    send_beat(ircc_pkg::FUNC_CLEAR, b, 1'b0);
    // Acquire ending exactly where a gate starts.
    a = '{id: 32'd10, start: 48'd100, stop: 48'd200, port: 8'd1,
          kind: ircc_pkg::KIND_ACQ, targets: 32'h1, res: 32'h0, excl: 32'hffffffff};
    send_beat(ircc_pkg::FUNC_STAGE, a, 1'b0);
    b = a; b.id = 32'd11; b.start = 48'd200; b.stop = 48'd300; b.port = 8'd2;
    b.kind = ircc_pkg::KIND_GATE;
    send_beat(ircc_pkg::FUNC_STAGE, b, 1'b1);
    // Exclusive resource shared; repeated id within a batch.
    a.id = 32'd20; a.kind = ircc_pkg::KIND_PULSE; a.targets = '0; a.res = 32'h80000000;
    a.excl = 32'h80000000; a.port = 8'd3;
    send_beat(ircc_pkg::FUNC_STAGE, a, 1'b1);
    b = a; b.id = 32'd21; b.port = 8'd4; b.excl = '0;
    send_beat(ircc_pkg::FUNC_STAGE, b, 1'b0);
    b.id = 32'd21;
    send_beat(ircc_pkg::FUNC_STAGE, b, 1'b1);
    // Batch overflow, then an open batch dropped by a discard.
    for (int i = 0; i < ircc_pkg::BATCH_DEPTH + 1; i++) begin
      a = '{id: 32'(100 + i), start: 48'(1000 + 10 * i), stop: 48'(1005 + 10 * i),
            port: 8'(50 + i), kind: ircc_pkg::KIND_PULSE, targets: '0, res: '0,
            excl: '0};
      send_beat(ircc_pkg::FUNC_STAGE, a, i == ircc_pkg::BATCH_DEPTH);
    end
    send_beat(ircc_pkg::FUNC_STAGE, a, 1'b0);
    a.start = 48'd250;
    send_beat(ircc_pkg::FUNC_DISCARD, a, 1'b1);
    send_beat(FUNC_SPARE, a, 1'b1);
    drain();

    // Fill the table to overflow.
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < ircc_pkg::BATCH_DEPTH; j++) begin
        a = '{id: 32'(500 + 8 * i + j), start: 48'(5000 + 8 * i + j),
              stop: 48'(5001 + 8 * i + j), port: 8'(8 * i + j),
              kind: ircc_pkg::KIND_PULSE, targets: '0, res: '0, excl: '0};
        send_beat(ircc_pkg::FUNC_STAGE, a, j == ircc_pkg::BATCH_DEPTH - 1);
      end
    a.start = 48'hffffffffffff;
    send_beat(ircc_pkg::FUNC_DISCARD, a, 1'b0);

    // Random: batches of random length, with discards and clears between.
    while (beats_sent < 840) begin
      n = $urandom_range(1, 10);
      for (int j = 0; j < n; j++)
        send_beat(ircc_pkg::FUNC_STAGE, rand_action($urandom_range(0, 9) == 0),
                  (j == n - 1) || ($urandom_range(0, 19) == 0));
      case ($urandom_range(0, 9))
        0: begin
          a = rand_action(0);
          a.start = 48'($urandom_range(0, 5000));
          send_beat(ircc_pkg::FUNC_DISCARD, a, 1'($urandom));
        end
        1: send_beat(($urandom_range(0, 3) == 0) ? FUNC_SPARE : ircc_pkg::FUNC_CLEAR,
                     rand_action(1), 1'($urandom));
        default: ;
      endcase
      if (beats_sent > 400 && beats_sent < 412) drain();
    end
    drain();

    $display("Covered %0d request beats: %0d batches committed, %0d rejected.",
             beats_sent, board.commits, board.conflicts);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("interval_resource_conflict_checker_tb OK");
    end else begin
      $display("interval_resource_conflict_checker_tb NOT OK");
    end
    $finish;
  end
endmodule
